### rtl/core/stbs_pkg.sv
// shared types and constants for the sort-then-binary-search block
// no dependencies

package stbs_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int ELEM_W    = 32;
	localparam int SLOT_W    = 3;
	localparam int KIND_W    = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_SEARCH
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic                     sort_en;
		logic                     phase;
		logic signed [ELEM_W-1:0] wr_data;
	} cell_ctl_t;

	// status of the binary search unit
	typedef struct packed {
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] pos;
	} probe_st_t;

endpackage

### rtl/core/stbs_cell.sv
// one table cell: holds an element, compare-exchanges with a neighbor
// uses stbs_pkg

module stbs_cell #(
	parameter bit PARITY    = 1'b0,
	parameter bit HAS_LEFT  = 1'b0,
	parameter bit HAS_RIGHT = 1'b0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stbs_pkg::cell_ctl_t               ctl,
	input  logic                              wr_en,
	input  logic signed [stbs_pkg::ELEM_W-1:0] left_val,
	input  logic signed [stbs_pkg::ELEM_W-1:0] right_val,
	input  logic signed [stbs_pkg::ELEM_W-1:0] key,
	output logic signed [stbs_pkg::ELEM_W-1:0] val,
	output logic                              key_lt,
	output logic                              key_eq
);
	import stbs_pkg::*;

	logic signed [ELEM_W-1:0] val_q;
	logic                     pair_right;
	logic                     pair_left;
	logic signed [ELEM_W-1:0] val_d;

	assign pair_right = ctl.sort_en && (ctl.phase == PARITY) && HAS_RIGHT;
	assign pair_left  = ctl.sort_en && (ctl.phase != PARITY) && HAS_LEFT;

	always_comb begin
		val_d = val_q;
		if (wr_en) begin
			val_d = ctl.wr_data;
		end else if (pair_right) begin
			// lower cell of the pair keeps the minimum
			if (right_val < val_q) begin
				val_d = right_val;
			end
		end else if (pair_left) begin
			// upper cell of the pair keeps the maximum
			if (left_val > val_q) begin
				val_d = left_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_d;
		end
	end

	assign val    = val_q;
	assign key_lt = key < val_q;
	assign key_eq = key == val_q;

endmodule

### rtl/core/stbs_probe.sv
// binary search unit: one probe of the sorted cell row per cycle while step is high
// uses stbs_pkg; reads key flags from the cell row

module stbs_probe #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  step,
	input  logic [DEPTH-1:0]      lt_vec,
	input  logic [DEPTH-1:0]      eq_vec,
	output stbs_pkg::probe_st_t   status
);
	import stbs_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW = IW + 2;

	logic signed [BW-1:0] lo_q;
	logic signed [BW-1:0] hi_q;
	logic signed [BW-1:0] sum;
	logic signed [BW-1:0] mid;
	logic                 empty;
	logic                 mid_eq;
	logic                 mid_lt;

	assign sum    = lo_q + hi_q;
	assign mid    = sum >>> 1;
	assign empty  = lo_q > hi_q;
	assign mid_eq = eq_vec[mid[IW-1:0]];
	assign mid_lt = lt_vec[mid[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (start) begin
			lo_q <= '0;
			hi_q <= BW'(DEPTH - 1);
		end else if (step && !empty && !mid_eq) begin
			if (mid_lt) begin
				hi_q <= mid - BW'(1);
			end else begin
				lo_q <= mid + BW'(1);
			end
		end
	end

	always_comb begin
		status.done = empty || mid_eq;
		status.hit  = !empty && mid_eq;
		status.pos  = status.hit ? mid[SLOT_W-1:0] : '0;
	end

endmodule

### rtl/core/sort_then_binary_search.sv
// top level of the sort-then-binary-search block
// uses stbs_pkg, stbs_cell, stbs_probe
//
// usage
//   input channel (in_valid / in_stall) carries kind, slot, operand.
//   a load request writes operand into cell slot and gives no result;
//   slots at or beyond DEPTH and kind 3 are dropped silently.
//   a read request returns the element at slot on read_data (0 when
//   slot is beyond the table) in the cycle after acceptance.
//   a search request sorts the table ascending in place, then runs a
//   binary search for operand; hit and where_found come back with
//   read_data at 0.
//   a search runs DEPTH passes of odd-even transposition in the
//   cell row, then one probe a cycle (at most clog2(DEPTH)+1 probes),
//   then the result goes into the output register.
//   only one request is in flight while a sort or search runs: the
//   input channel stalls until the block is idle again.
//   output channel (out_valid / out_stall) is a single output register.
//   while a result is stalled, loads and searches are still taken; a
//   read waits, and a finished search holds its answer until the
//   register frees up.
//   reset clears every cell to zero and empties the output register.

module sort_then_binary_search #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [stbs_pkg::KIND_W-1:0]        kind,
	input  logic [stbs_pkg::SLOT_W-1:0]        slot,
	input  logic signed [stbs_pkg::ELEM_W-1:0] operand,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [stbs_pkg::SLOT_W-1:0]        where_found,
	output logic signed [stbs_pkg::ELEM_W-1:0] read_data
);
	import stbs_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q;
	state_t state_d;

	logic [CW-1:0]            cnt_q;
	logic signed [ELEM_W-1:0] key_q;

	logic                     out_valid_q;
	logic                     hit_q;
	logic [SLOT_W-1:0]        where_q;
	logic signed [ELEM_W-1:0] rdata_q;

	logic                     accept;
	logic                     out_free;
	logic                     slot_ok;
	logic                     sort_last;
	logic                     probe_start;
	logic                     probe_step;
	logic                     res_load;
	logic signed [ELEM_W-1:0] rd_mux;

	cell_ctl_t                ctl;
	probe_st_t                pst;

	logic signed [ELEM_W-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]         wr_vec;
	logic [DEPTH-1:0]         lt_vec;
	logic [DEPTH-1:0]         eq_vec;

	// handshake; a read needs the output register, a search only at its end
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (!out_free && (kind == KIND_READ));
	assign accept   = in_valid && !in_stall;
	assign slot_ok  = 32'(slot) < DEPTH;

	assign sort_last = cnt_q == CW'(DEPTH - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_SEARCH)) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (sort_last) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (pst.done && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ctl.sort_en = 1'b0;
		ctl.phase   = cnt_q[0];
		ctl.wr_data = operand;
		probe_start = 1'b0;
		probe_step  = 1'b0;
		res_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_SORT: begin
				ctl.sort_en = 1'b1;
				probe_start = sort_last;
			end
			ST_SEARCH: begin
				probe_step = 1'b1;
				res_load   = pst.done && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SORT) begin
				cnt_q <= sort_last ? '0 : cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_SEARCH)) begin
			key_q <= operand;
		end
	end

	// per-cell write strobes and read selection
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < DEPTH; i++) begin
			wr_vec[i] = accept && (kind == KIND_LOAD) && slot_ok && (32'(slot) == i);
			if (slot_ok && (32'(slot) == i)) begin
				rd_mux = cell_val[i];
			end
		end
	end

	// the cell row: each cell sees its neighbors (an end cell sees only one)
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [ELEM_W-1:0] lval;
		logic signed [ELEM_W-1:0] rval;

		if (g > 0) begin : g_l
			assign lval = cell_val[g-1];
		end else begin : g_l0
			assign lval = '0;
		end
		if (g < DEPTH - 1) begin : g_r
			assign rval = cell_val[g+1];
		end else begin : g_r0
			assign rval = '0;
		end

		stbs_cell #(
			.PARITY   (1'(g % 2)),
			.HAS_LEFT (g > 0),
			.HAS_RIGHT(g < DEPTH - 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (wr_vec[g]),
			.left_val (lval),
			.right_val(rval),
			.key      (key_q),
			.val      (cell_val[g]),
			.key_lt   (lt_vec[g]),
			.key_eq   (eq_vec[g])
		);
	end

	stbs_probe #(
		.DEPTH(DEPTH)
	) u_probe (
		.clk   (clk),
		.arst_n(arst_n),
		.start (probe_start),
		.step  (probe_step),
		.lt_vec(lt_vec),
		.eq_vec(eq_vec),
		.status(pst)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || (accept && (kind == KIND_READ))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			hit_q   <= pst.hit;
			where_q <= pst.pos;
			rdata_q <= '0;
		end else if (accept && (kind == KIND_READ)) begin
			hit_q   <= 1'b0;
			where_q <= '0;
			rdata_q <= rd_mux;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign where_found = where_q;
	assign read_data   = rdata_q;

	// table is ascending whenever the search runs
	logic row_sorted;
	always_comb begin
		row_sorted = 1'b1;
		for (int i = 0; i + 1 < DEPTH; i++) begin
			if (cell_val[i] > cell_val[i+1]) begin
				row_sorted = 1'b0;
			end
		end
	end

	a_sorted_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> row_sorted)
		else $error("cell row not sorted during search");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |-> 32'(cnt_q) < DEPTH)
		else $error("sort pass count out of range");

	a_key_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH && $past(state_q == ST_SEARCH) |-> $stable(key_q))
		else $error("search key changed mid search");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |->
			$past(state_q == ST_SEARCH) || $past(accept && (kind == KIND_READ)))
		else $error("result appeared without a read or search");

	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && pst.hit |-> eq_vec != '0)
		else $error("hit reported with no matching cell");

endmodule
